>>> rtl/wsh_pkg.sv
package wsh_pkg;

   // Width of the window id on the result channel.
   localparam int ID_W = 5;

   // Command codes on the request channel.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_CLICK = 1'b1;

   // One result beat as handed from the stack controller to the output register.
   typedef struct packed {
      logic            valid;
      logic            hit;
      logic [ID_W-1:0] window_id;
   } result_type;

endpackage

>>> rtl/wsh_req_if.sv
interface wsh_req_if #(
   parameter int COORD_BITS = 12
) ();

   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [COORD_BITS-1:0] left_x;
   logic [COORD_BITS-1:0] bottom_y;
   logic [COORD_BITS-1:0] right_x;
   logic [COORD_BITS-1:0] top_y;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;

   modport source (
      output valid, cmd, left_x, bottom_y, right_x, top_y, point_x, point_y,
      input  ready
   );

   modport sink (
      input  valid, cmd, left_x, bottom_y, right_x, top_y, point_x, point_y,
      output ready
   );

endinterface

>>> rtl/wsh_rsp_if.sv
interface wsh_rsp_if import wsh_pkg::*; ();

   logic            valid;
   logic            ready;
   logic            hit;
   logic [ID_W-1:0] window_id;

   modport source (
      output valid, hit, window_id,
      input  ready
   );

   modport sink (
      input  valid, hit, window_id,
      output ready
   );

endinterface

>>> rtl/wsh_rect_store.sv
module wsh_rect_store import wsh_pkg::*; #(
   parameter int MAX_WINDOWS = 16,
   parameter int COORD_BITS  = 12,
   localparam int IDX_W      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1,
   localparam int RECT_W     = 4 * COORD_BITS
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [RECT_W-1:0]     wr_rect,
   input  logic [IDX_W-1:0]      rd_addr,
   input  logic [COORD_BITS-1:0] point_x,
   input  logic [COORD_BITS-1:0] point_y,
   output logic                  hit
);

   logic [RECT_W-1:0]     rect_mem [MAX_WINDOWS];
   logic [RECT_W-1:0]     rect_rd_ff;
   logic [COORD_BITS-1:0] left_x;
   logic [COORD_BITS-1:0] bottom_y;
   logic [COORD_BITS-1:0] right_x;
   logic [COORD_BITS-1:0] top_y;

   // Rectangle memory, one entry per window in load order, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rect_mem[wr_addr] <= wr_rect;
      end
      rect_rd_ff <= rect_mem[rd_addr];
   end

   // Unpack the entry read in the previous cycle.
   assign left_x   = rect_rd_ff[4*COORD_BITS-1:3*COORD_BITS];
   assign bottom_y = rect_rd_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign right_x  = rect_rd_ff[2*COORD_BITS-1:COORD_BITS];
   assign top_y    = rect_rd_ff[COORD_BITS-1:0];

   // Containment test with all four bounds inclusive.
   assign hit = (left_x <= point_x) && (point_x <= right_x) &&
                (bottom_y <= point_y) && (point_y <= top_y);

endmodule

>>> rtl/wsh_stack_ctrl.sv
module wsh_stack_ctrl import wsh_pkg::*; #(
   parameter int MAX_WINDOWS = 16,
   parameter int COORD_BITS  = 12,
   localparam int IDX_W      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1,
   localparam int CNT_W      = $clog2(MAX_WINDOWS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_cmd,
   input  logic [COORD_BITS-1:0] in_point_x,
   input  logic [COORD_BITS-1:0] in_point_y,
   output logic                  rect_wr_en,
   output logic [IDX_W-1:0]      rect_wr_addr,
   output logic [IDX_W-1:0]      rect_rd_addr,
   output logic [COORD_BITS-1:0] point_x,
   output logic [COORD_BITS-1:0] point_y,
   input  logic                  rect_hit,
   output result_type            result,
   input  logic                  result_ready
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_SHIFT  = 3'd2;
   localparam logic [2:0] ST_FRONT  = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [IDX_W-1:0]      order_mem [MAX_WINDOWS];
   logic [IDX_W-1:0]      order_rd_ff;
   logic [IDX_W-1:0]      order_raddr;
   logic [IDX_W-1:0]      order_wdata;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  click_ff, click_in;
   logic                  iss_act_ff, iss_act_in;
   logic [IDX_W-1:0]      iss_pos_ff, iss_pos_in;
   logic                  s1_v_ff, s1_v_in;
   logic [IDX_W-1:0]      s1_pos_ff, s1_pos_in;
   logic                  s2_v_ff, s2_v_in;
   logic [IDX_W-1:0]      s2_pos_ff, s2_pos_in;
   logic [IDX_W-1:0]      s2_idx_ff, s2_idx_in;
   logic [IDX_W-1:0]      sh_ptr_ff, sh_ptr_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  res_hit_ff, res_hit_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0]      wr_addr_ff, wr_addr_in;
   logic                  wr_from_rd_ff, wr_from_rd_in;
   logic [COORD_BITS-1:0] px_ff, px_in;
   logic [COORD_BITS-1:0] py_ff, py_in;

   logic                  accept;
   logic                  full;
   logic [IDX_W-1:0]      last_pos;
   logic [IDX_W-1:0]      count_idx;

   // Stack order memory: position 0 is the top. A write always lands in the cycle
   // after the read that produced its data, so reads and writes never collide.
   assign order_wdata = wr_from_rd_ff ? order_rd_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         order_mem[wr_addr_ff] <= order_wdata;
      end
      order_rd_ff <= order_mem[order_raddr];
   end

   assign accept    = in_valid && in_ready;
   assign full      = (count_ff == CNT_W'(MAX_WINDOWS));
   assign last_pos  = IDX_W'(count_ff - CNT_W'(1));
   assign count_idx = IDX_W'(count_ff);

   // Sequencer: a click walks the stack and, on a hit, shifts the entries above
   // it down and writes it on top; a load shifts all entries, then writes on top.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      click_in      = click_ff;
      iss_act_in    = iss_act_ff;
      iss_pos_in    = iss_pos_ff;
      s1_v_in       = 1'b0;
      s1_pos_in     = iss_pos_ff;
      s2_v_in       = 1'b0;
      s2_pos_in     = s1_pos_ff;
      s2_idx_in     = order_rd_ff;
      sh_ptr_in     = sh_ptr_ff;
      idx_in        = idx_ff;
      res_hit_in    = res_hit_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_from_rd_in = wr_from_rd_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      order_raddr   = iss_pos_ff;
      rect_wr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (in_cmd == CMD_CLICK) begin
                  click_in   = 1'b1;
                  px_in      = in_point_x;
                  py_in      = in_point_y;
                  res_hit_in = 1'b0;
                  if (count_ff == '0) begin
                     state_in = ST_RESULT;
                  end else begin
                     state_in   = ST_SEARCH;
                     iss_act_in = 1'b1;
                     iss_pos_in = '0;
                  end
               end else if (!full) begin
                  // A new window takes the next store slot and goes on top.
                  click_in   = 1'b0;
                  rect_wr_en = 1'b1;
                  sh_ptr_in  = count_idx;
                  idx_in     = count_idx;
                  count_in   = count_ff + CNT_W'(1);
                  state_in   = (count_ff == '0) ? ST_FRONT : ST_SHIFT;
               end
            end
         end

         ST_SEARCH: begin
            // Issue one stack position per cycle; its result comes back through the order and rectangle read registers.
            if (iss_act_ff) begin
               s1_v_in = 1'b1;
               if (iss_pos_ff == last_pos) begin
                  iss_act_in = 1'b0;
               end else begin
                  iss_pos_in = iss_pos_ff + IDX_W'(1);
               end
            end
            if (s1_v_ff) begin
               s2_v_in = 1'b1;
            end
            // The first hit wins; anything still in flight is dropped.
            if (s2_v_ff && rect_hit) begin
               res_hit_in = 1'b1;
               idx_in     = s2_idx_ff;
               sh_ptr_in  = s2_pos_ff;
               iss_act_in = 1'b0;
               s1_v_in    = 1'b0;
               s2_v_in    = 1'b0;
               state_in   = (s2_pos_ff == '0) ? ST_FRONT : ST_SHIFT;
            end else if (s2_v_ff && (s2_pos_ff == last_pos)) begin
               state_in = ST_RESULT;
            end
         end

         ST_SHIFT: begin
            // Move the entry above the write pointer one place down.
            order_raddr   = sh_ptr_ff - IDX_W'(1);
            wr_pend_in    = 1'b1;
            wr_addr_in    = sh_ptr_ff;
            wr_from_rd_in = 1'b1;
            if (sh_ptr_ff == IDX_W'(1)) begin
               state_in = ST_FRONT;
            end else begin
               sh_ptr_in = sh_ptr_ff - IDX_W'(1);
            end
         end

         ST_FRONT: begin
            wr_pend_in    = 1'b1;
            wr_addr_in    = '0;
            wr_from_rd_in = 1'b0;
            state_in      = click_ff ? ST_RESULT : ST_IDLE;
         end

         ST_RESULT: begin
            if (result_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         iss_act_ff <= 1'b0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         iss_act_ff <= iss_act_in;
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s2_v_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      click_ff      <= click_in;
      iss_pos_ff    <= iss_pos_in;
      s1_pos_ff     <= s1_pos_in;
      s2_pos_ff     <= s2_pos_in;
      s2_idx_ff     <= s2_idx_in;
      sh_ptr_ff     <= sh_ptr_in;
      idx_ff        <= idx_in;
      res_hit_ff    <= res_hit_in;
      wr_addr_ff    <= wr_addr_in;
      wr_from_rd_ff <= wr_from_rd_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
   end

   assign in_ready     = (state_ff == ST_IDLE);
   assign rect_wr_addr = count_idx;
   assign rect_rd_addr = order_rd_ff;
   assign point_x      = px_ff;
   assign point_y      = py_ff;

   // Ids count from one in load order and are cut to the id field.
   assign result.valid     = (state_ff == ST_RESULT);
   assign result.hit       = res_hit_ff;
   assign result.window_id = res_hit_ff ? ID_W'({1'b0, idx_ff} + 1'b1) : '0;

endmodule

>>> rtl/window_stack_hit_test_top.sv
// Channel   Direction  Beat contents
// req_chan  in         cmd, left_x, bottom_y, right_x, top_y, point_x, point_y
// rsp_chan  out        hit, window_id (one beat per click, none per load)
//
// One item at a time. A load moves every window already loaded one place down, as
// the stack order memory shifts one entry a cycle. A click searches from the top and,
// on a hit at stack position P, shifts the P entries above it. Reset is synchronous
// and empties the stack. A result waiting in the output register does not hold off
// loads; a click only stalls at its end until that register is free.
module window_stack_hit_test_top import wsh_pkg::*; #(
   parameter int MAX_WINDOWS = 16,
   parameter int COORD_BITS  = 12
) (
   input  logic       clock,
   input  logic       reset,
   wsh_req_if.sink    req_chan,
   wsh_rsp_if.source  rsp_chan
);

   localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

   logic                  rect_wr_en;
   logic [IDX_W-1:0]      rect_wr_addr;
   logic [IDX_W-1:0]      rect_rd_addr;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   logic                  rect_hit;
   result_type            result;
   logic                  result_ready;
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [ID_W-1:0]       rsp_id_ff;

   wsh_stack_ctrl #(
      .MAX_WINDOWS (MAX_WINDOWS),
      .COORD_BITS  (COORD_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .in_cmd       (req_chan.cmd),
      .in_point_x   (req_chan.point_x),
      .in_point_y   (req_chan.point_y),
      .rect_wr_en   (rect_wr_en),
      .rect_wr_addr (rect_wr_addr),
      .rect_rd_addr (rect_rd_addr),
      .point_x      (point_x),
      .point_y      (point_y),
      .rect_hit     (rect_hit),
      .result       (result),
      .result_ready (result_ready)
   );

   wsh_rect_store #(
      .MAX_WINDOWS (MAX_WINDOWS),
      .COORD_BITS  (COORD_BITS)
   ) u_rects (
      .clock   (clock),
      .wr_en   (rect_wr_en),
      .wr_addr (rect_wr_addr),
      .wr_rect ({req_chan.left_x, req_chan.bottom_y, req_chan.right_x, req_chan.top_y}),
      .rd_addr (rect_rd_addr),
      .point_x (point_x),
      .point_y (point_y),
      .hit     (rect_hit)
   );

   // Output register: takes a new result when empty or being drained.
   assign result_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid && result_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid && result_ready) begin
         rsp_hit_ff <= result.hit;
         rsp_id_ff  <= result.window_id;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.hit       = rsp_hit_ff;
   assign rsp_chan.window_id = rsp_id_ff;

endmodule

>>> test/window_stack_hit_test_top_tb.sv
`timescale 1ns / 1ps

module window_stack_hit_test_top_tb import wsh_pkg::*; ();

   localparam int MAX_WINDOWS  = 16;
   localparam int COORD_BITS   = 12;
   localparam int IDX_W        = $clog2(MAX_WINDOWS);
   localparam int RANDOM_BEATS = 1124;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;

   typedef logic [COORD_BITS-1:0] coord_type;

   // One stored window, bounds inclusive.
   typedef struct packed {
      coord_type lo_x;
      coord_type lo_y;
      coord_type hi_x;
      coord_type hi_y;
   } window_rect_type;

   typedef struct packed {
      logic            hit;
      logic [ID_W-1:0] window_id;
   } click_result_type;

   // One request beat, with an optional hand-written expectation for clicks.
   typedef struct packed {
      logic            cmd;
      coord_type       left_x;
      coord_type       bottom_y;
      coord_type       right_x;
      coord_type       top_y;
      coord_type       point_x;
      coord_type       point_y;
      logic            pinned;
      logic            exp_hit;
      logic [ID_W-1:0] exp_id;
   } stim_row_type;

   logic clock;
   logic reset;

   wsh_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   wsh_rsp_if rsp_chan ();

   window_stack_hit_test_top #(
      .MAX_WINDOWS (MAX_WINDOWS),
      .COORD_BITS  (COORD_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the window stack.
   window_rect_type  win_rect [MAX_WINDOWS];
   logic [IDX_W-1:0] z_order [MAX_WINDOWS];
   int unsigned      win_count = 0;

   click_result_type pending_results [$];
   int               mismatches = 0;
   int               idle_cycles = 0;
   bit               calm = 1'b0;

   // Hand-written expectation travelling with the current request beat.
   logic             beat_pinned = 1'b0;
   click_result_type beat_pinned_result = '0;

   // Directed rows: empty stack, inclusive bounds, inverted windows, a full store,
   // the highest id and ignored fields of the other command.
   stim_row_type directed_rows [26] = '{
      '{CMD_CLICK,    0,    0,    0,    0,    0,    0, 1, 0,  0},
      '{CMD_LOAD,     0,    0, 4095, 2047, 4095, 4095, 0, 0,  0},
      '{CMD_CLICK,    0,    0,    0,    0, 4095, 2047, 1, 1,  1},
      '{CMD_CLICK,    0,    0,    0,    0, 2000, 2048, 1, 0,  0},
      '{CMD_LOAD,  4095,    0,    0, 4095,    0,    0, 0, 0,  0},
      '{CMD_CLICK,    0,    0,    0,    0, 2000, 2000, 1, 1,  1},
      '{CMD_LOAD,   100,  200,  300,  400,  123,  456, 0, 0,  0},
      '{CMD_CLICK,    0,    0,    0,    0,  100,  200, 1, 1,  3},
      '{CMD_CLICK,    0,    0,    0,    0,  301,  400, 1, 1,  1},
      '{CMD_LOAD,     0, 4095, 4095,    0,    0,    0, 0, 0,  0},
      '{CMD_LOAD,   500,  500,  650,  650,    0,    0, 0, 0,  0},
      '{CMD_LOAD,   600,  600,  750,  750,    0,    0, 0, 0,  0},
      '{CMD_LOAD,   700,  700,  850,  850,    0,    0, 0, 0,  0},
      '{CMD_LOAD,   800,  800,  950,  950,    0,    0, 0, 0,  0},
      '{CMD_LOAD,   900,  900, 1050, 1050,    0,    0, 0, 0,  0},
      '{CMD_LOAD,  1000, 1000, 1150, 1150,    0,    0, 0, 0,  0},
      '{CMD_LOAD,  1100, 1100, 1250, 1250,    0,    0, 0, 0,  0},
      '{CMD_LOAD,  1200, 1200, 1350, 1350,    0,    0, 0, 0,  0},
      '{CMD_LOAD,  1300, 1300, 1450, 1450,    0,    0, 0, 0,  0},
      '{CMD_LOAD,  1400, 1400, 1550, 1550,    0,    0, 0, 0,  0},
      '{CMD_LOAD,  1500, 1500, 1650, 1650,    0,    0, 0, 0,  0},
      '{CMD_LOAD,  1600, 1600, 1750, 1750,    0,    0, 0, 0,  0},
      '{CMD_LOAD,     0,    0, 4095, 4095,    0,    0, 0, 0,  0},
      '{CMD_CLICK, 4095, 4095, 4095, 4095, 4095, 4095, 1, 0,  0},
      '{CMD_CLICK,    0,    0,    0,    0, 1650, 1650, 1, 1, 16},
      '{CMD_CLICK,    0,    0,    0,    0, 1550, 1550, 0, 0,  0}
   };

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Append a window on top of the stack, unless the store is full.
   function automatic void stack_load(window_rect_type r);
      if (win_count >= MAX_WINDOWS) return;
      win_rect[win_count] = r;
      for (int i = win_count; i > 0; i--) z_order[i] = z_order[i-1];
      z_order[0] = IDX_W'(win_count);
      win_count++;
   endfunction

   // Walk the stack from the top; the first window holding the point moves to the top.
   function automatic click_result_type stack_click(coord_type px, coord_type py);
      click_result_type res;
      logic [IDX_W-1:0] idx;
      window_rect_type r;
      res = '0;
      for (int pos = 0; pos < win_count; pos++) begin
         idx = z_order[pos];
         r = win_rect[idx];
         if (r.lo_x <= px && px <= r.hi_x && r.lo_y <= py && py <= r.hi_y) begin
            for (int i = pos; i > 0; i--) z_order[i] = z_order[i-1];
            z_order[0] = idx;
            res.hit = 1'b1;
            res.window_id = ID_W'(idx) + ID_W'(1);
            return res;
         end
      end
      return res;
   endfunction

   // Idle cycles before a beat; none at all during a calm stretch.
   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 9);
   endfunction

   // Random beat: mostly clicks aimed at, on or just beside a stored window.
   function automatic stim_row_type random_row();
      stim_row_type row;
      window_rect_type t;
      int mode;
      row = '0;
      row.cmd = ($urandom_range(0, 99) < 8) ? CMD_LOAD : CMD_CLICK;
      row.left_x = coord_type'($urandom);
      row.bottom_y = coord_type'($urandom);
      row.right_x = coord_type'($urandom);
      row.top_y = coord_type'($urandom);
      row.point_x = coord_type'($urandom);
      row.point_y = coord_type'($urandom);
      t = win_rect[$urandom_range(0, win_count - 1)];
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
         row.point_x = coord_type'($urandom_range(t.hi_x, t.lo_x));
         row.point_y = coord_type'($urandom_range(t.hi_y, t.lo_y));
      end else begin
         case (mode)
            5: begin
               row.point_x = $urandom_range(0, 1) ? t.lo_x : t.hi_x;
               row.point_y = $urandom_range(0, 1) ? t.lo_y : t.hi_y;
            end
            6: begin
               // One step beyond an edge; the step may wrap at the coordinate limits.
               row.point_x = coord_type'($urandom_range(t.hi_x, t.lo_x));
               row.point_y = coord_type'($urandom_range(t.hi_y, t.lo_y));
               case ($urandom_range(0, 3))
                  0: row.point_x = t.lo_x - 1'b1;
                  1: row.point_x = t.hi_x + 1'b1;
                  2: row.point_y = t.lo_y - 1'b1;
                  default: row.point_y = t.hi_y + 1'b1;
               endcase
            end
            7: ;
            default: begin
               row.point_x = $urandom_range(0, 1) ? '1 : '0;
               row.point_y = $urandom_range(0, 1) ? '1 : '0;
            end
         endcase
      end
      return row;
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatches++;
   endtask

   // Drive one request beat after an optional gap and wait until it is accepted.
   task automatic send_beat(stim_row_type row, int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.cmd       <= row.cmd;
      req_chan.left_x    <= row.left_x;
      req_chan.bottom_y  <= row.bottom_y;
      req_chan.right_x   <= row.right_x;
      req_chan.top_y     <= row.top_y;
      req_chan.point_x   <= row.point_x;
      req_chan.point_y   <= row.point_y;
      beat_pinned        <= row.pinned;
      beat_pinned_result <= '{row.exp_hit, row.exp_id};
      req_chan.valid     <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold the request side quiet until every expected result has arrived.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Request monitor: update the shadow stack and queue the expected result of a click.
   always @(posedge clock) begin
      click_result_type predicted;
      if (!reset && req_chan.valid && req_chan.ready) begin
         if (req_chan.cmd == CMD_LOAD) begin
            stack_load('{req_chan.left_x, req_chan.bottom_y,
                         req_chan.right_x, req_chan.top_y});
         end else begin
            predicted = stack_click(req_chan.point_x, req_chan.point_y);
            pending_results.push_back(beat_pinned ? beat_pinned_result : predicted);
         end
      end
   end

   // Result checker: each accepted beat against the oldest expectation.
   always @(posedge clock) begin
      click_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result hit=%0d id=%0d with nothing expected",
                                      rsp_chan.hit, rsp_chan.window_id));
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.hit !== want.hit)
               report_mismatch($sformatf("hit %b, expected %b", rsp_chan.hit, want.hit));
            if (rsp_chan.window_id !== want.window_id)
               report_mismatch($sformatf("window_id %0d, expected %0d",
                                         rsp_chan.window_id, want.window_id));
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stall before each beat.
   initial begin
      int stall;
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (reset || !rsp_chan.valid);
      end
   end

   // Request side: reset, directed table, then random beats.
   initial begin
      int beats_sent;
      stim_row_type row;
      beats_sent = 0;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.cmd      <= CMD_LOAD;
      req_chan.left_x   <= '0;
      req_chan.bottom_y <= '0;
      req_chan.right_x  <= '0;
      req_chan.top_y    <= '0;
      req_chan.point_x  <= '0;
      req_chan.point_y  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_beat(directed_rows[i], draw_gap());
      drain_results();

      while (beats_sent < RANDOM_BEATS) begin
         // Every fourth stretch of beats runs with no idling on either side.
         calm = ((beats_sent / 75) % 4) == 3;
         row = random_row();
         send_beat(row, draw_gap());
         beats_sent++;
         if (beats_sent % 300 == 0) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/wsh_pkg.sv
rtl/wsh_req_if.sv
rtl/wsh_rsp_if.sv
rtl/wsh_rect_store.sv
rtl/wsh_stack_ctrl.sv
rtl/window_stack_hit_test_top.sv
test/window_stack_hit_test_top_tb.sv
